// ===== src/vgm_psg_command_compactor_top_macros.svh =====
// Assertion macros shared by the compactor's checker.
`ifndef VGM_PSG_COMMAND_COMPACTOR_TOP_MACROS_SVH
`define VGM_PSG_COMMAND_COMPACTOR_TOP_MACROS_SVH

// Next-cycle implication, held off while reset is asserted.
`define VPCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("compactor check failed");

// Next-cycle implication that also covers the reset cycles.
`define VPCC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("compactor reset check failed");

`endif

// ===== src/vpcc_pkg.sv =====
// Shared constants and types for the VGM PSG command compactor.
package vpcc_pkg;

    // Header skip count
    localparam logic [6:0] HEADER_BYTES   = 7'd64;

    // Command codes
    localparam logic [7:0] CMD_GG_STEREO  = 8'h4F;
    localparam logic [7:0] CMD_PSG_WRITE  = 8'h50;
    localparam logic [7:0] CMD_WAIT_LONG  = 8'h61;
    localparam logic [7:0] CMD_WAIT_60    = 8'h62;
    localparam logic [7:0] CMD_WAIT_50    = 8'h63;
    localparam logic [7:0] CMD_END        = 8'h66;

    // Output codes
    localparam logic [7:0] CODE_WAIT      = 8'h40;
    localparam logic [7:0] CODE_END       = 8'h60;
    localparam logic [7:0] PSG_DATA_MASK  = 8'h3F;

    // x / 17 for 16-bit x: (x * 61681) >> 20, exact since 17 * 61681 = 2^20 + 1
    localparam logic [15:0] DIV17_RECIP   = 16'd61681;
    localparam int          DIV17_SHIFT   = 20;
    localparam int          WAIT_BITS     = 5;

    // Output queue
    localparam int          QUEUE_DEPTH   = 4;
    localparam int          QUEUE_AW      = 2;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_CMD     = 4'b0001,
        PH_OPERAND = 4'b0010,
        PH_WAIT_LO = 4'b0100,
        PH_WAIT_HI = 4'b1000
    } t_phase;

    // One queued result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_result;

endpackage

// ===== src/vgm_psg_command_compactor_top.sv =====
// A result is written into the output queue when its byte is accepted and is offered from there.
// Throughput: one byte per cycle while bytes give at most one result each and the
//   output does not stall; a byte that gives two results (a result plus the end code)
//   takes two queue entries, and the 4-entry queue sets how far input may run ahead.
// Reset (synchronous, active low) empties the queue and rearms the parser.
module vgm_psg_command_compactor_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_file,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_in_run
);
    import vpcc_pkg::*;

    // Parser state
    logic [6:0]  r_header_left, n_header_left;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_pending_command, n_pending_command;
    logic [7:0]  r_wait_low_byte, n_wait_low_byte;
    logic        r_finished, n_finished;

    // Output queue
    t_result             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_count;

    logic        in_acc, out_acc;
    logic        main_valid, saw_end, add_end;
    logic [7:0]  main_byte;
    logic [1:0]  res_cnt;
    logic [15:0] wait_count;
    logic [31:0] wait_prod;
    logic [WAIT_BITS-1:0] wait_steps;
    logic [QUEUE_AW-1:0]  wr_next;

    // Handshakes: take a byte only with room for two results
    assign o_in_ready  = (r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign out_acc     = o_out_valid && i_out_ready;
    assign o_out_byte    = r_mem[r_rd].out_byte;
    assign o_last_in_run = r_mem[r_rd].last;

    // Long wait: divide the sample count by 17 by reciprocal multiply
    assign wait_count = {i_in_byte, r_wait_low_byte};
    assign wait_prod  = wait_count * DIV17_RECIP;
    assign wait_steps = wait_prod[DIV17_SHIFT +: WAIT_BITS];

    // Decode of one byte
    always_comb begin
        n_header_left     = r_header_left;
        n_phase           = r_phase;
        n_pending_command = r_pending_command;
        n_wait_low_byte   = r_wait_low_byte;
        n_finished        = r_finished;
        main_valid        = 1'b0;
        main_byte         = '0;
        saw_end           = 1'b0;
        add_end           = 1'b0;

        if (r_finished) begin
            // after the end command only the end of file matters
        end else if (r_header_left != '0) begin
            n_header_left = r_header_left - 7'd1;
        end else begin
            unique case (r_phase)
                PH_OPERAND: begin
                    if (r_pending_command == CMD_PSG_WRITE) begin
                        main_valid = 1'b1;
                        main_byte  = i_in_byte[7] ? i_in_byte : (i_in_byte & PSG_DATA_MASK);
                    end
                    n_phase = PH_CMD;
                end
                PH_WAIT_LO: begin
                    n_wait_low_byte = i_in_byte;
                    n_phase         = PH_WAIT_HI;
                end
                PH_WAIT_HI: begin
                    if (wait_steps != '0) begin
                        main_valid = 1'b1;
                        main_byte  = CODE_WAIT + {3'b000, wait_steps};
                    end
                    n_phase = PH_CMD;
                end
                PH_CMD: begin
                    unique case (i_in_byte) inside
                        CMD_GG_STEREO, CMD_PSG_WRITE: begin
                            n_pending_command = i_in_byte;
                            n_phase           = PH_OPERAND;
                        end
                        CMD_WAIT_LONG: begin
                            n_phase = PH_WAIT_LO;
                        end
                        CMD_WAIT_60, CMD_WAIT_50: begin
                            main_valid = 1'b1;
                            main_byte  = CODE_WAIT;
                        end
                        CMD_END: begin
                            main_valid = 1'b1;
                            main_byte  = CODE_END;
                            saw_end    = 1'b1;
                        end
                        // short waits (0x7n) divide to zero; unknown bytes: nothing
                        default: begin
                        end
                    endcase
                end
                default: begin
                    n_phase = PH_CMD;
                end
            endcase
        end

        // End of file: close the stream and rearm
        if (i_end_of_file) begin
            add_end           = !r_finished && !saw_end;
            n_header_left     = HEADER_BYTES;
            n_phase           = PH_CMD;
            n_pending_command = '0;
            n_wait_low_byte   = '0;
            n_finished        = 1'b0;
        end else if (saw_end) begin
            n_finished = 1'b1;
        end

        res_cnt = {1'b0, main_valid} + {1'b0, add_end};
    end

    assign wr_next = r_wr + QUEUE_AW'(1);

    // State and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_left     <= HEADER_BYTES;
            r_phase           <= PH_CMD;
            r_pending_command <= '0;
            r_wait_low_byte   <= '0;
            r_finished        <= 1'b0;
            r_wr              <= '0;
            r_rd              <= '0;
            r_count           <= '0;
        end else begin
            if (in_acc) begin
                r_header_left     <= n_header_left;
                r_phase           <= n_phase;
                r_pending_command <= n_pending_command;
                r_wait_low_byte   <= n_wait_low_byte;
                r_finished        <= n_finished;
                r_wr              <= r_wr + QUEUE_AW'(res_cnt);
            end
            if (out_acc) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            r_count <= r_count + (in_acc ? (QUEUE_AW+1)'(res_cnt) : '0)
                       - (QUEUE_AW+1)'(out_acc);
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (main_valid) begin
                r_mem[r_wr] <= '{out_byte: main_byte, last: !add_end};
                if (add_end) begin
                    r_mem[wr_next] <= '{out_byte: CODE_END, last: 1'b1};
                end
            end else if (add_end) begin
                r_mem[r_wr] <= '{out_byte: CODE_END, last: 1'b1};
            end
        end
    end

endmodule

// ===== src/vpcc_checker.sv =====
// Port-level checker for the compactor, bound to the top level.
`include "vgm_psg_command_compactor_top_macros.svh"

module vpcc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_in_byte,
    input logic       i_end_of_file,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last_in_run
);

    // Reset empties the queue and opens the input
    `VPCC_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_out_valid)
    `VPCC_ASSERT_NEXT_ALWAYS(a_rst_ready, i_clk, !i_rst_n, o_in_ready)

    // No result appears without an input transaction
    `VPCC_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n,
        !o_out_valid && !(i_in_valid && o_in_ready), !o_out_valid)

    // A stalled result holds
    `VPCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_byte) && $stable(o_last_in_run))

endmodule

bind vgm_psg_command_compactor_top vpcc_checker u_vpcc_checker (.*);

// ===== tb/sv/tb_vgm_psg_command_compactor_top.sv =====
// Self-checking testbench for the VGM PSG command compactor: random byte streams vs. a predictor.
module tb_vgm_psg_command_compactor_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vpcc_pkg::*;

    localparam int unsigned SAMPLES_PER_STEP = 882 / 50;
    localparam logic [3:0]  SHORT_WAIT_NIBBLE = 4'h7;
    localparam int          LONG_STALL       = 400;
    localparam int          WATCHDOG_LIMIT   = 2000;
    localparam int          LIVE_PER_PHASE   = 230;
    localparam int          MAX_REPORTS      = 10;

    typedef struct {
        logic [7:0] data;
        logic       eof;
    } t_vgm_in;

    // DUT ports
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_in_byte     = 8'h00;
    logic       i_end_of_file = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready   = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_last_in_run;

    // Stimulus and expected compact stream
    t_vgm_in vgm_bytes_q[$];
    t_result compact_q[$];

    // Predictor state
    logic [6:0] hdr_left;
    t_phase     vgm_phase;
    logic [7:0] pend_cmd;
    logic [7:0] wait_lo;
    logic       vgm_done;

    // Run control
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int stall_reqs    = 0;
    int mismatch_cnt  = 0;
    int quiet_cycles  = 0;

    vgm_psg_command_compactor_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_end_of_file (i_end_of_file),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_in_run (o_last_in_run)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Parser back to its power-up state
    function automatic void rearm_parser();
        hdr_left  = HEADER_BYTES;
        vgm_phase = PH_CMD;
        pend_cmd  = 8'h00;
        wait_lo   = 8'h00;
        vgm_done  = 1'b0;
    endfunction

    // Decode one accepted byte and queue the compact bytes it produces
    function automatic void decode_vgm_byte(input logic [7:0] b, input logic eof);
        t_result     res[$];
        t_result     r;
        logic        saw_end;
        logic [15:0] cnt;
        int unsigned quot;
        saw_end = 1'b0;
        r.last  = 1'b0;
        // after the end command only end of input matters
        if (vgm_done) begin
            if (eof)
                rearm_parser();
            return;
        end
        if (hdr_left != 7'd0) begin
            hdr_left = hdr_left - 7'd1;
        end else begin
            case (vgm_phase)
                PH_OPERAND: begin
                    if (pend_cmd == CMD_PSG_WRITE) begin
                        r.out_byte = b[7] ? b : (b & PSG_DATA_MASK);
                        res.push_back(r);
                    end
                    vgm_phase = PH_CMD;
                end
                PH_WAIT_LO: begin
                    wait_lo   = b;
                    vgm_phase = PH_WAIT_HI;
                end
                PH_WAIT_HI: begin
                    cnt  = {b, wait_lo};
                    quot = (cnt / SAMPLES_PER_STEP) % 32;
                    if (quot != 0) begin
                        r.out_byte = CODE_WAIT + 8'(quot);
                        res.push_back(r);
                    end
                    vgm_phase = PH_CMD;
                end
                default: begin
                    if (b == CMD_GG_STEREO || b == CMD_PSG_WRITE) begin
                        pend_cmd  = b;
                        vgm_phase = PH_OPERAND;
                    end else if (b == CMD_WAIT_LONG) begin
                        vgm_phase = PH_WAIT_LO;
                    end else if (b == CMD_WAIT_60 || b == CMD_WAIT_50) begin
                        r.out_byte = CODE_WAIT;
                        res.push_back(r);
                    end else if (b == CMD_END) begin
                        r.out_byte = CODE_END;
                        res.push_back(r);
                        saw_end = 1'b1;
                    end else if (b[7:4] == SHORT_WAIT_NIBBLE) begin
                        // nibble / 17 is always zero, kept for completeness
                        quot = ({28'd0, b[3:0]} / SAMPLES_PER_STEP) % 32;
                        if (quot != 0) begin
                            r.out_byte = CODE_WAIT + 8'(quot);
                            res.push_back(r);
                        end
                    end
                    // anything else is an unknown command: dropped
                end
            endcase
        end
        // end of input closes the stream and rearms
        if (eof) begin
            if (!saw_end) begin
                r.out_byte = CODE_END;
                res.push_back(r);
            end
            rearm_parser();
        end else if (saw_end) begin
            vgm_done = 1'b1;
        end
        if (res.size() != 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[k])
            compact_q.push_back(res[k]);
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t ns mismatch: %s", $realtime, what);
    endtask

    task automatic push_vgm(input logic [7:0] b, input logic eof);
        t_vgm_in it;
        it.data = b;
        it.eof  = eof;
        vgm_bytes_q.push_back(it);
    endtask

    // Header bytes; the last one optionally marks end of input
    task automatic add_header(input int len, input logic eof_last);
        int i;
        for (i = 0; i < len; i++)
            push_vgm(8'($urandom_range(255)), eof_last && (i == len - 1));
    endtask

    // One random file; live counts the command bytes it carries
    task automatic add_vgm_file(output int live);
        int          i;
        int          n_cmds;
        int          pick;
        int          n_tail;
        logic [15:0] cnt;
        live = 0;
        // now and then the file stops inside the header
        if ($urandom_range(11) == 0) begin
            add_header($urandom_range(1, HEADER_BYTES), 1'b1);
            return;
        end
        add_header(HEADER_BYTES, 1'b0);
        n_cmds = $urandom_range(10, 60);
        for (i = 0; i < n_cmds; i++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                push_vgm(CMD_PSG_WRITE, 1'b0);
                push_vgm(8'($urandom_range(255)), 1'b0);
                live += 2;
            end else if (pick < 45) begin
                push_vgm(CMD_GG_STEREO, 1'b0);
                push_vgm(8'($urandom_range(255)), 1'b0);
                live += 2;
            end else if (pick < 60) begin
                cnt = $urandom_range(1) ? 16'($urandom_range(600)) : 16'($urandom_range(65535));
                push_vgm(CMD_WAIT_LONG, 1'b0);
                push_vgm(cnt[7:0], 1'b0);
                push_vgm(cnt[15:8], 1'b0);
                live += 3;
            end else if (pick < 72) begin
                push_vgm($urandom_range(1) ? CMD_WAIT_60 : CMD_WAIT_50, 1'b0);
                live += 1;
            end else if (pick < 82) begin
                push_vgm({SHORT_WAIT_NIBBLE, 4'($urandom_range(15))}, 1'b0);
                live += 1;
            end else begin
                // noise: any byte at all
                push_vgm(8'($urandom_range(255)), 1'b0);
                live += 1;
            end
        end
        // how the file closes
        case ($urandom_range(6))
            0: begin
                push_vgm(CMD_END, 1'b1);
                live += 1;
            end
            1: begin
                push_vgm(CMD_END, 1'b0);
                n_tail = $urandom_range(1, 4);
                for (i = 0; i < n_tail; i++)
                    push_vgm(8'($urandom_range(255)), 1'b0);
                push_vgm(8'($urandom_range(255)), 1'b1);
                live += 1;
            end
            2: begin
                push_vgm(8'($urandom_range(255)), 1'b1);
                live += 1;
            end
            3: begin
                push_vgm($urandom_range(1) ? CMD_WAIT_60 : CMD_WAIT_50, 1'b1);
                live += 1;
            end
            4: begin
                push_vgm(CMD_WAIT_LONG, 1'b0);
                push_vgm(8'($urandom_range(255)), 1'b0);
                push_vgm(8'($urandom_range(255)), 1'b1);
                live += 3;
            end
            5: begin
                push_vgm(CMD_PSG_WRITE, 1'b0);
                push_vgm(8'($urandom_range(255)), 1'b1);
                live += 2;
            end
            default: begin
                // command cut short by end of input
                push_vgm($urandom_range(1) ? CMD_WAIT_LONG : CMD_PSG_WRITE, 1'b1);
                live += 1;
            end
        endcase
    endtask

    // Sender: offers queued bytes, predicts on each accepted transaction
    always @(posedge i_clk) begin : drive_bytes
        t_vgm_in nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                decode_vgm_byte(i_in_byte, i_end_of_file);
            if (!i_in_valid || o_in_ready) begin
                if (vgm_bytes_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = vgm_bytes_q.pop_front();
                    i_in_valid    <= 1'b1;
                    i_in_byte     <= nxt.data;
                    i_end_of_file <= nxt.eof;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random backpressure plus a requested long hold-off; checks results
    always @(posedge i_clk) begin : sink_results
        t_result exp_res;
        int      stall_seen;
        int      stall_left;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_seen = 0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (compact_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected result %02h last=%0b",
                                            o_out_byte, o_last_in_run));
                end else begin
                    exp_res = compact_q.pop_front();
                    if (o_out_byte !== exp_res.out_byte || o_last_in_run !== exp_res.last)
                        note_mismatch($sformatf("expected %02h last=%0b, got %02h last=%0b",
                                                exp_res.out_byte, exp_res.last,
                                                o_out_byte, o_last_in_run));
                end
            end
            if (stall_reqs != stall_seen) begin
                stall_seen = stall_reqs;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog: too long without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Test sequence
    initial begin : run_test
        int i;
        int live;
        int live_total;
        int phase_no;
        rearm_parser();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_pct  = 27;
        sink_idle_pct = 65;

        // directed: header with extreme bytes, then each command kind
        for (i = 0; i < HEADER_BYTES; i++)
            push_vgm((i % 2 == 0) ? 8'hFF : 8'h00, 1'b0);
        push_vgm(CMD_GG_STEREO, 1'b0);  push_vgm(8'h55, 1'b0);
        push_vgm(CMD_PSG_WRITE, 1'b0);  push_vgm(8'h7F, 1'b0);
        push_vgm(CMD_PSG_WRITE, 1'b0);  push_vgm(8'h80, 1'b0);
        push_vgm(CMD_WAIT_60, 1'b0);
        push_vgm(CMD_WAIT_50, 1'b0);
        push_vgm(CMD_WAIT_LONG, 1'b0);  push_vgm(8'h00, 1'b0);  push_vgm(8'h00, 1'b0);
        push_vgm(CMD_WAIT_LONG, 1'b0);  push_vgm(8'hFF, 1'b0);  push_vgm(8'hFF, 1'b0);
        push_vgm(CMD_WAIT_LONG, 1'b0);  push_vgm(8'h11, 1'b0);  push_vgm(8'h00, 1'b0);
        push_vgm({SHORT_WAIT_NIBBLE, 4'hF}, 1'b0);
        push_vgm(8'h00, 1'b0);
        push_vgm(CMD_END, 1'b0);
        push_vgm(8'h23, 1'b0);
        push_vgm(8'h9A, 1'b1);
        // end of input inside the header
        add_header(3, 1'b1);
        // PSG write landing on end of input: data then end code
        add_header(HEADER_BYTES, 1'b0);
        push_vgm(CMD_PSG_WRITE, 1'b0);  push_vgm(8'hC3, 1'b1);
        // long wait cut short
        add_header(HEADER_BYTES, 1'b0);
        push_vgm(CMD_WAIT_LONG, 1'b0);  push_vgm(8'h10, 1'b1);
        // end command on the last byte
        add_header(HEADER_BYTES, 1'b0);
        push_vgm(CMD_END, 1'b1);

        // three random phases with different idling
        for (phase_no = 0; phase_no < 3; phase_no++) begin
            // sender holds back until the block has delivered everything
            while (vgm_bytes_q.size() != 0 || i_in_valid || compact_q.size() != 0)
                @(negedge i_clk);
            case (phase_no)
                0: begin src_idle_pct = 27; sink_idle_pct = 65; end
                1: begin src_idle_pct = 65; sink_idle_pct = 27; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            live_total = 0;
            while (live_total < LIVE_PER_PHASE) begin
                add_vgm_file(live);
                live_total += live;
            end
            // full-rate phase: freeze the output so the block backs up
            if (phase_no == 2)
                stall_reqs++;
        end

        // drain, then wait for anything stray
        while (vgm_bytes_q.size() != 0 || i_in_valid || compact_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
